// ===== design/nfcd_pkg.sv =====
package nfcd_pkg;

    localparam logic [7:0] DIR_CODE_RESET = 8'hD5;
    localparam logic [7:0] HDR_ZERO       = 8'h00;
    localparam logic [7:0] HDR_START      = 8'hFF;
    localparam logic [7:0] POSTAMBLE      = 8'h00;

    typedef enum logic [3:0] {
        PH_HDR0 = 4'd0,
        PH_HDR1 = 4'd1,
        PH_HDR2 = 4'd2,
        PH_LEN  = 4'd3,
        PH_LCS  = 4'd4,
        PH_DIR  = 4'd5,
        PH_DATA = 4'd6,
        PH_POST = 4'd7,
        PH_DONE = 4'd8
    } phase_t;

    // One result from the parser, handed to the output stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       is_status;
        logic       frame_ok;
        logic [7:0] frame_length;
    } result_t;

endpackage

// ===== design/nfcd_parser.sv =====
module nfcd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             end_of_buffer,
    input  logic [7:0]       direction_code,
    output nfcd_pkg::result_t res
);
    import nfcd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;

    logic       chk_fail;
    logic       chk_ok;
    logic       fwd;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    // Per-phase checks on the current byte.
    always_comb
    begin
        chk_fail = 1'b0;
        chk_ok   = 1'b0;
        fwd      = 1'b0;
        unique case (phase_reg)
            PH_HDR0: chk_fail = (rx_byte != HDR_ZERO);
            PH_HDR1: chk_fail = (rx_byte != HDR_ZERO);
            PH_HDR2: chk_fail = (rx_byte != HDR_START);
            PH_LEN:  chk_fail = 1'b0;
            PH_LCS:  chk_fail = (rx_byte == 8'h00) || ((length_reg + rx_byte) != 8'h00);
            PH_DIR:  chk_fail = (rx_byte != direction_code);
            PH_DATA: fwd      = 1'b1;
            PH_POST:
            begin
                chk_ok   = (rx_byte == POSTAMBLE);
                chk_fail = (rx_byte != POSTAMBLE);
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (end_of_buffer)
            begin
                phase_next  = PH_HDR0;
                length_next = 8'h00;
                count_next  = 8'h00;
            end
            else if (chk_ok || chk_fail)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR0: phase_next = PH_HDR1;
                    PH_HDR1: phase_next = PH_HDR2;
                    PH_HDR2: phase_next = PH_LEN;
                    PH_LEN:
                    begin
                        length_next = rx_byte;
                        phase_next  = PH_LCS;
                    end
                    PH_LCS:  phase_next = PH_DIR;
                    PH_DIR:
                    begin
                        count_next = 8'h00;
                        phase_next = (length_reg == 8'h00) ? PH_POST : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        count_next = count_inc;
                        if (count_inc == length_reg)
                            phase_next = PH_POST;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // Result for the accepted byte.
    always_comb
    begin
        res = '0;
        if (accept && (phase_reg != PH_DONE))
        begin
            if (chk_ok)
            begin
                res.valid        = 1'b1;
                res.is_status    = 1'b1;
                res.frame_ok     = 1'b1;
                res.frame_length = length_reg;
            end
            else if (chk_fail || end_of_buffer)
            begin
                res.valid     = 1'b1;
                res.is_status = 1'b1;
            end
            else if (fwd)
            begin
                res.valid    = 1'b1;
                res.out_byte = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            length_reg <= 8'h00;
            count_reg  <= 8'h00;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_buffer |=> phase_reg == PH_HDR0 && count_reg == 8'h00)
        else $error("parser did not restart after last byte");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> !res.valid)
        else $error("result after frame status");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> count_reg < length_reg)
        else $error("payload count ran past length");

endmodule

// ===== design/nfc_frame_deframer_top.sv =====
// Channel  Dir  Handshake                Content
// s_*      in   s_tvalid/s_tready        tdata[7:0] rx_byte, tlast end_of_buffer
// m_*      out  m_tvalid/m_tready        tdata out_byte/frame_ok/frame_length,
//                                        tuser is_status
// cfg_*    in   cfg_valid/cfg_ready      cfg_data direction_code
//
// One byte per cycle while s_tready is high: each transfer is parsed in the
// cycle it is accepted and its result is written to the output register, or
// to skid if it stays full, at that edge; m_tvalid is high in the next cycle.
// A two-entry output (register plus skid) lets input flow while one result
// waits; s_tready drops only when both entries are full.
// Reset (async, active low) clears parser state, output valids and sets
// direction_code to 0xD5. cfg_ready is always high.
module nfc_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [8] frame_ok,
                                   // [16:9] frame_length, [23:17] zero
    output logic        m_tuser,   // is_status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // direction_code
);
    import nfcd_pkg::*;

    logic       cfg_write;
    logic [7:0] dir_reg;
    logic       s_accept;
    logic       m_pop;
    result_t    res;

    // Output register and skid entry.
    logic       out_valid_reg;
    result_t    out_reg;
    logic       skid_valid_reg;
    result_t    skid_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= DIR_CODE_RESET;
        else if (cfg_write)
            dir_reg <= cfg_data;
    end

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_pop    = out_valid_reg & m_tready;

    nfcd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (s_accept),
        .rx_byte        (s_tdata),
        .end_of_buffer  (s_tlast),
        .direction_code (dir_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // No transfer accepted while skid is full.
                if (m_pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res.valid)
            begin
                if (!out_valid_reg || m_pop)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (m_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload, no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_pop)
                out_reg <= skid_reg;
        end
        else if (res.valid)
        begin
            if (!out_valid_reg || m_pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.frame_length, out_reg.frame_ok, out_reg.out_byte};
    assign m_tuser  = out_reg.is_status;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> out_valid_reg)
        else $error("result lost");

endmodule
